[hdl/wmq_pkg.sv]
// Shared types and constants for the windowed M/G/1 queue delay estimator.
package wmq_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int ARR_W = 48;
    localparam int SVC_W = 24;
    localparam int WIN_W = 32;
    localparam int SQ_IN_W = 2 * SVC_W;
    localparam int ENTRY_W = ARR_W + SVC_W;
    localparam int IN_DATA_W = 120;
    localparam logic [WIN_W-1:0] WINDOW_RESET = 32'd1000000;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic rd_head;
        logic rd_prev;
        logic drop;
        logic div1_start;
        logic mul;
        logic prep;
        logic div2_start;
        logic fin;
        logic zero_delay;
        logic set_ovf;
        logic idx_init;
        logic shift;
        logic insert;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic cnt_zero;
        logic cnt_le1;
        logic cnt_full;
        logic win_zero;
        logic idx_zero;
        logic evict_hit;
        logic shift_hit;
        logic div_done;
    } status_t;

endpackage

[hdl/wmq_div.sv]
// Restoring divider, one quotient bit per cycle.
module wmq_div #(
    parameter int DVD_W = 61,
    parameter int DVS_W = 33
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0] quot_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic             done_reg;
    logic [DVS_W:0]   trial;
    logic             take;

    // Shift in the next dividend bit and try the subtraction
    always_comb
    begin
        trial = {rem_reg, quot_reg[DVD_W-1]};
        take  = (trial >= {1'b0, dvs_reg});
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Advance the quotient and remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[DVD_W-2:0], take};
            rem_reg  <= take ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

[hdl/wmq_datapath.sv]
// Datapath: request store, running sums, delay arithmetic and output registers.
module wmq_datapath #(
    parameter int STORE_DEPTH = wmq_pkg::DEPTH_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  wmq_pkg::cmd_t                      cmd,
    output wmq_pkg::status_t                   status,
    input  logic [wmq_pkg::IN_DATA_W-1:0]      in_data,
    input  logic                               cfg_we,
    input  logic [wmq_pkg::WIN_W-1:0]          cfg_wdata,
    output logic [wmq_pkg::WIN_W-1:0]          out_delay,
    output logic                               out_ovf
);
    import wmq_pkg::*;

    localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W = $clog2(STORE_DEPTH + 1);
    localparam int SUM_W = SVC_W + CNT_W;
    localparam int SQ_W  = SQ_IN_W + CNT_W;
    localparam int DVD_W = SQ_W + 6;
    localparam int DVS_W = WIN_W + 1;
    localparam int CMP_W = ((SUM_W > WIN_W) ? SUM_W : WIN_W) + 7;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STORE_DEPTH);
    localparam logic [IDX_W:0]   DEPTH_PH  = (IDX_W + 1)'(STORE_DEPTH);

    logic [ENTRY_W-1:0] mem [STORE_DEPTH];

    logic [WIN_W-1:0]   window_reg;
    logic [ARR_W-1:0]   arr_reg;
    logic [SVC_W-1:0]   svc_reg;
    logic [ARR_W-1:0]   thr_reg;
    logic [SQ_IN_W-1:0] in_sq_reg;
    logic [IDX_W-1:0]   head_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [SQ_W-1:0]    sq_sum_reg;
    logic [ENTRY_W-1:0] rd_reg;
    logic [SQ_IN_W-1:0] rsq_reg;
    logic [SQ_W-1:0]    p_reg;
    logic [DVD_W-1:0]   dvd_reg;
    logic [DVS_W-1:0]   dvs_reg;
    logic [WIN_W-1:0]   delay_reg;
    logic               ovf_reg;
    logic [WIN_W-1:0]   out_delay_reg;
    logic               out_ovf_reg;

    logic [ARR_W-1:0]   in_arr;
    logic [SVC_W-1:0]   in_svc;
    logic [ARR_W-1:0]   in_glob;
    logic [ARR_W-1:0]   t1;
    logic [ARR_W-1:0]   t2;
    logic [ARR_W-1:0]   win10;
    logic [ARR_W-1:0]   rd_arr;
    logic [SVC_W-1:0]   rd_svc;
    logic [IDX_W-1:0]   head_ph;
    logic [IDX_W-1:0]   prev_ph;
    logic [IDX_W-1:0]   cur_ph;
    logic [CNT_W-1:0]   idx_m1;
    logic               div_start;
    logic [DVD_W-1:0]   div_dvd;
    logic [DVS_W-1:0]   div_dvs;
    logic               div_done;
    logic [DVD_W-1:0]   div_q;
    logic               cap;
    logic [WIN_W-1:0]   w_minus_s;

    // Map a logical slot onto the circular store
    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                              input logic [CNT_W-1:0] slot);
        logic [IDX_W:0] s;
        s = {1'b0, head} + (IDX_W + 1)'(slot);
        if (s >= DEPTH_PH)
            s = s - DEPTH_PH;
        return s[IDX_W-1:0];
    endfunction

    assign in_arr  = in_data[ARR_W-1:0];
    assign in_svc  = in_data[ARR_W+SVC_W-1:ARR_W];
    assign in_glob = in_data[2*ARR_W+SVC_W-1:ARR_W+SVC_W];
    assign rd_arr  = rd_reg[ARR_W-1:0];
    assign rd_svc  = rd_reg[ENTRY_W-1:ARR_W];

    // Eviction threshold parts, both saturating at zero
    always_comb
    begin
        win10 = ARR_W'(window_reg) * ARR_W'(10);
        t1 = (in_glob > ARR_W'(window_reg)) ? in_glob - ARR_W'(window_reg) : '0;
        t2 = (in_arr > win10) ? in_arr - win10 : '0;
    end

    // Slot addresses
    always_comb
    begin
        idx_m1  = idx_reg - 1'b1;
        head_ph = head_reg;
        prev_ph = phys(head_reg, idx_m1);
        cur_ph  = phys(head_reg, idx_reg);
    end

    // Utilization cap test and the subtrahend of the plain branch
    always_comb
    begin
        cap = (CMP_W'(sum_reg) * CMP_W'(100)) > (CMP_W'(window_reg) * CMP_W'(99));
        w_minus_s = window_reg - WIN_W'(sum_reg);
    end

    // Divider operands
    always_comb
    begin
        div_start = cmd.div1_start | cmd.div2_start;
        if (cmd.div1_start)
        begin
            div_dvd = DVD_W'(sq_sum_reg);
            div_dvs = DVS_W'(cnt_reg);
        end
        else
        begin
            div_dvd = dvd_reg;
            div_dvs = dvs_reg;
        end
    end

    wmq_div #(
        .DVD_W(DVD_W),
        .DVS_W(DVS_W)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(div_dvd),
        .divisor (div_dvs),
        .done    (div_done),
        .quotient(div_q)
    );

    // Control state: window, head, count, sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
            head_reg   <= '0;
            cnt_reg    <= '0;
            sum_reg    <= '0;
            sq_sum_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                window_reg <= cfg_wdata;
            if (cmd.drop)
            begin
                head_reg   <= (head_reg == IDX_W'(STORE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                cnt_reg    <= cnt_reg - 1'b1;
                sum_reg    <= sum_reg - SUM_W'(rd_svc);
                sq_sum_reg <= sq_sum_reg - SQ_W'(rsq_reg);
            end
            else if (cmd.insert)
            begin
                cnt_reg    <= cnt_reg + 1'b1;
                sum_reg    <= sum_reg + SUM_W'(svc_reg);
                sq_sum_reg <= sq_sum_reg + SQ_W'(in_sq_reg);
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rsq_reg <= SQ_IN_W'(rd_svc) * SQ_IN_W'(rd_svc);
        if (cmd.load)
        begin
            arr_reg <= in_arr;
            svc_reg <= in_svc;
            thr_reg <= (t1 > t2) ? t1 : t2;
            ovf_reg <= 1'b0;
        end
        else if (cmd.set_ovf)
            ovf_reg <= 1'b1;
        in_sq_reg <= SQ_IN_W'(svc_reg) * SQ_IN_W'(svc_reg);
        if (cmd.idx_init)
            idx_reg <= cnt_reg;
        else if (cmd.shift)
            idx_reg <= idx_m1;
        if (cmd.mul)
            p_reg <= SQ_W'(cnt_reg) * div_q[SQ_W-1:0];
        if (cmd.prep)
        begin
            if (cap)
            begin
                dvd_reg <= DVD_W'(p_reg) * DVD_W'(50);
                dvs_reg <= DVS_W'(window_reg);
            end
            else
            begin
                dvd_reg <= DVD_W'(p_reg);
                dvs_reg <= {w_minus_s, 1'b0};
            end
        end
        if (cmd.zero_delay)
            delay_reg <= '0;
        else if (cmd.fin)
            delay_reg <= (div_q > DVD_W'(window_reg)) ? window_reg : div_q[WIN_W-1:0];
        if (cmd.out_load)
        begin
            out_delay_reg <= delay_reg;
            out_ovf_reg   <= ovf_reg;
        end
    end

    // Store: one read and one write port
    always_ff @(posedge clk)
    begin
        if (cmd.rd_head)
            rd_reg <= mem[head_ph];
        else if (cmd.rd_prev)
            rd_reg <= mem[prev_ph];
        if (cmd.shift)
            mem[cur_ph] <= rd_reg;
        else if (cmd.insert)
            mem[cur_ph] <= {svc_reg, arr_reg};
    end

    always_comb
    begin
        status.cnt_zero  = (cnt_reg == '0);
        status.cnt_le1   = (cnt_reg <= CNT_W'(1));
        status.cnt_full  = (cnt_reg == DEPTH_CNT);
        status.win_zero  = (window_reg == '0);
        status.idx_zero  = (idx_reg == '0);
        status.evict_hit = (rd_arr < thr_reg);
        status.shift_hit = (rd_arr > arr_reg);
        status.div_done  = div_done;
    end

    assign out_delay = out_delay_reg;
    assign out_ovf   = out_ovf_reg;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= DEPTH_CNT)
        else $error("store count above depth");
    a_drop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.drop |-> cnt_reg != '0)
        else $error("drop from empty store");
    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert |-> cnt_reg < DEPTH_CNT)
        else $error("insert into full store");
    a_delay_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin |=> delay_reg <= window_reg)
        else $error("delay above window");

endmodule

[hdl/wmq_ctrl.sv]
// Controller: sequences eviction, delay computation, insertion and output.
module wmq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  wmq_pkg::status_t  status,
    output wmq_pkg::cmd_t     cmd
);
    import wmq_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_EV_RD, S_EV_CHK, S_EV_DROP, S_DLY, S_DIV1, S_MUL, S_PREP,
        S_D2GO, S_DIV2, S_FIN, S_FULL, S_FU_CHK, S_FU_DROP, S_INS_RD,
        S_INS_CHK, S_INS_WR, S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;

    // Decode commands and next state
    always_comb
    begin
        cmd           = '0;
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EV_RD;
                end
            end
            S_EV_RD:
            begin
                if (status.cnt_zero)
                    state_next = S_DLY;
                else
                begin
                    cmd.rd_head = 1'b1;
                    state_next  = S_EV_CHK;
                end
            end
            S_EV_CHK:  state_next = status.evict_hit ? S_EV_DROP : S_DLY;
            S_EV_DROP:
            begin
                cmd.drop   = 1'b1;
                state_next = S_EV_RD;
            end
            S_DLY:
            begin
                if (status.cnt_le1 || status.win_zero)
                begin
                    cmd.zero_delay = 1'b1;
                    state_next     = S_FULL;
                end
                else
                begin
                    cmd.div1_start = 1'b1;
                    state_next     = S_DIV1;
                end
            end
            S_DIV1:    if (status.div_done) state_next = S_MUL;
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_PREP;
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_D2GO;
            end
            S_D2GO:
            begin
                cmd.div2_start = 1'b1;
                state_next     = S_DIV2;
            end
            S_DIV2:    if (status.div_done) state_next = S_FIN;
            S_FIN:
            begin
                cmd.fin    = 1'b1;
                state_next = S_FULL;
            end
            S_FULL:
            begin
                if (status.cnt_full)
                begin
                    cmd.rd_head = 1'b1;
                    cmd.set_ovf = 1'b1;
                    state_next  = S_FU_CHK;
                end
                else
                begin
                    cmd.idx_init = 1'b1;
                    state_next   = S_INS_RD;
                end
            end
            S_FU_CHK:  state_next = S_FU_DROP;
            S_FU_DROP:
            begin
                cmd.drop   = 1'b1;
                state_next = S_FULL;
            end
            S_INS_RD:
            begin
                if (status.idx_zero)
                    state_next = S_INS_WR;
                else
                begin
                    cmd.rd_prev = 1'b1;
                    state_next  = S_INS_CHK;
                end
            end
            S_INS_CHK:
            begin
                if (status.shift_hit)
                begin
                    cmd.shift  = 1'b1;
                    state_next = S_INS_RD;
                end
                else
                    state_next = S_INS_WR;
            end
            S_INS_WR:
            begin
                cmd.insert = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // Hold state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == S_EV_RD)
        else $error("load did not start eviction");
    a_out_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> m_tvalid_reg)
        else $error("result loaded without valid");
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div1_start |=> state_reg == S_DIV1 && !status.div_done)
        else $error("divider done too early");

endmodule

[hdl/windowed_mg1_queue_delay.sv]
// Top level of the windowed M/G/1 queue delay estimator.
// One request transaction at a time. Each request ages out old entries, computes
// the delay, drops the oldest entry if the store is full and is then sorted in
// past newer entries. DVD_W = 54 + clog2(STORE_DEPTH+1) is the width of the
// bit-serial divider used twice (61 at the default depth).
// The store reads and writes one entry per cycle. With fewer than two stored
// requests or a zero window the divider is skipped. The result waits in an
// output register; a new request is taken once the previous result is loaded.
module windowed_mg1_queue_delay #(
    parameter int STORE_DEPTH = wmq_pkg::DEPTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // arrival_time[47:0], svc_time[71:48], global_time[119:72]
    input  logic [wmq_pkg::IN_DATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // queue_delay[31:0]
    output logic [wmq_pkg::WIN_W-1:0]     m_tdata,
    // store_overflow[0]
    output logic                          m_tuser,
    input  logic                          cfg_we,
    input  logic [wmq_pkg::WIN_W-1:0]     cfg_wdata
);
    import wmq_pkg::*;

    cmd_t    cmd;
    status_t status;

    wmq_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .status  (status),
        .cmd     (cmd)
    );

    wmq_datapath #(
        .STORE_DEPTH(STORE_DEPTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .in_data  (s_tdata),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .out_delay(m_tdata),
        .out_ovf  (m_tuser)
    );

endmodule
